FILE: rtl/assert_macros.svh
// Assertion macros shared by the rasterizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tsr_pkg.sv
// Shared types and constants of the triangle span rasterizer.
`default_nettype none

package tsr_pkg;

    localparam int ADDR_BITS = 4;
    localparam int DATA_BITS = 32;
    localparam int COLOR_KEEP_BITS = 16;
    localparam int MASK_RIGHT_RESET = 1023;
    localparam int MASK_BOTTOM_RESET = 63;

    localparam logic [1:0] REG_MASK_LEFT = 2'd0;
    localparam logic [1:0] REG_MASK_TOP = 2'd1;
    localparam logic [1:0] REG_MASK_RIGHT = 2'd2;
    localparam logic [1:0] REG_MASK_BOTTOM = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SORT0,
        ST_SORT1,
        ST_SORT2,
        ST_CHECK,
        ST_AIM1,
        ST_AIM2,
        ST_ROW,
        ST_E1,
        ST_E1_MV,
        ST_E2,
        ST_FLUSH
    } tsr_state_t;

    typedef enum logic {
        OP_MOVE,
        OP_AIM
    } edge_op_t;

    typedef struct packed {
        logic push;
        logic flush;
    } span_ctl_t;

    typedef struct packed {
        logic push_ready;
        logic flush_done;
    } span_sts_t;

endpackage

`default_nettype wire

FILE: rtl/tsr_edge_unit.sv
// Shared Bresenham edge unit: sets up an edge or advances it one step.
`default_nettype none

module tsr_edge_unit #(
    parameter int COORD_BITS = 16,
    parameter int ERR_BITS = 19
) (
    input  tsr_pkg::edge_op_t               op,
    input  logic signed [COORD_BITS-1:0]    a_x,
    input  logic signed [COORD_BITS-1:0]    a_y,
    input  logic signed [COORD_BITS-1:0]    b_x,
    input  logic signed [COORD_BITS-1:0]    b_y,
    input  logic signed [COORD_BITS-1:0]    in_x,
    input  logic signed [COORD_BITS-1:0]    in_y,
    input  logic [COORD_BITS-1:0]           in_dx,
    input  logic [COORD_BITS-1:0]           in_dy,
    input  logic                            in_sxn,
    input  logic                            in_syn,
    input  logic signed [ERR_BITS-1:0]      in_err,
    output logic signed [COORD_BITS-1:0]    out_x,
    output logic signed [COORD_BITS-1:0]    out_y,
    output logic [COORD_BITS-1:0]           out_dx,
    output logic [COORD_BITS-1:0]           out_dy,
    output logic                            out_sxn,
    output logic                            out_syn,
    output logic signed [ERR_BITS-1:0]      out_err
);

    logic signed [COORD_BITS:0]   diff_x;
    logic signed [COORD_BITS:0]   diff_y;
    logic signed [COORD_BITS:0]   abs_x;
    logic signed [COORD_BITS:0]   abs_y;
    logic signed [ERR_BITS-1:0]   half_dx;
    logic signed [ERR_BITS-1:0]   half_dy;
    logic signed [ERR_BITS-1:0]   dx_e;
    logic signed [ERR_BITS-1:0]   dy_e;
    logic signed [ERR_BITS-1:0]   sub_v;
    logic signed [ERR_BITS-1:0]   add_v;
    logic                         step_x;
    logic                         step_y;

    always_comb
    begin
        diff_x = {a_x[COORD_BITS-1], a_x} - {b_x[COORD_BITS-1], b_x};
        diff_y = {a_y[COORD_BITS-1], a_y} - {b_y[COORD_BITS-1], b_y};
        abs_x = diff_x[COORD_BITS] ? -diff_x : diff_x;
        abs_y = diff_y[COORD_BITS] ? -diff_y : diff_y;
        half_dx = {{(ERR_BITS-COORD_BITS+1){1'b0}}, abs_x[COORD_BITS-1:1]};
        half_dy = {{(ERR_BITS-COORD_BITS+1){1'b0}}, abs_y[COORD_BITS-1:1]};

        dx_e = {{(ERR_BITS-COORD_BITS){1'b0}}, in_dx};
        dy_e = {{(ERR_BITS-COORD_BITS){1'b0}}, in_dy};
        step_x = in_err > -dx_e;
        step_y = in_err < dy_e;
        sub_v = step_x ? dy_e : '0;
        add_v = step_y ? dx_e : '0;

        case (op)
            tsr_pkg::OP_AIM:
            begin
                out_x = a_x;
                out_y = a_y;
                out_dx = abs_x[COORD_BITS-1:0];
                out_dy = abs_y[COORD_BITS-1:0];
                out_sxn = ~diff_x[COORD_BITS];
                out_syn = ~diff_y[COORD_BITS];
                out_err = (abs_x > abs_y) ? half_dx : -half_dy;
            end
            default:
            begin
                out_x = step_x ? (in_sxn ? in_x - 1'b1 : in_x + 1'b1) : in_x;
                out_y = step_y ? (in_syn ? in_y - 1'b1 : in_y + 1'b1) : in_y;
                out_dx = in_dx;
                out_dy = in_dy;
                out_sxn = in_sxn;
                out_syn = in_syn;
                out_err = in_err - sub_v + add_v;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/tsr_span_out.sv
// Span output stage: one pending span plus the output register, tags the last beat.
`default_nettype none

`include "assert_macros.svh"

module tsr_span_out #(
    parameter int COORD_BITS = 16,
    parameter int COLOR_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tsr_pkg::span_ctl_t              ctl,
    output tsr_pkg::span_sts_t              sts,
    input  logic signed [COORD_BITS-1:0]    push_row,
    input  logic signed [COORD_BITS-1:0]    push_start,
    input  logic signed [COORD_BITS-1:0]    push_end,
    input  logic [COLOR_BITS-1:0]           push_color,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [COORD_BITS-1:0]    span_row,
    output logic signed [COORD_BITS-1:0]    span_start,
    output logic signed [COORD_BITS-1:0]    span_end,
    output logic [COLOR_BITS-1:0]           span_color,
    output logic                            span_last
);

    logic                         pend_valid_reg;
    logic                         pend_valid_next;
    logic signed [COORD_BITS-1:0] pend_row_reg;
    logic signed [COORD_BITS-1:0] pend_start_reg;
    logic signed [COORD_BITS-1:0] pend_end_reg;
    logic [COLOR_BITS-1:0]        pend_color_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic signed [COORD_BITS-1:0] out_row_reg;
    logic signed [COORD_BITS-1:0] out_start_reg;
    logic signed [COORD_BITS-1:0] out_end_reg;
    logic [COLOR_BITS-1:0]        out_color_reg;
    logic                         out_last_reg;
    logic                         out_last_next;
    logic                         out_free;
    logic                         load_out;
    logic                         load_pend;

    always_comb
    begin
        out_free = !out_valid_reg || out_ready;
        sts.push_ready = !pend_valid_reg || out_free;
        sts.flush_done = !pend_valid_reg || out_free;
        pend_valid_next = pend_valid_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_last_next = out_last_reg;
        load_out = 1'b0;
        load_pend = 1'b0;
        if (ctl.push && sts.push_ready)
        begin
            load_pend = 1'b1;
            pend_valid_next = 1'b1;
            if (pend_valid_reg)
            begin
                load_out = 1'b1;
                out_last_next = 1'b0;
            end
        end
        else if (ctl.flush && pend_valid_reg && out_free)
        begin
            load_out = 1'b1;
            out_last_next = 1'b1;
            pend_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_pend)
        begin
            pend_row_reg <= push_row;
            pend_start_reg <= push_start;
            pend_end_reg <= push_end;
            pend_color_reg <= push_color;
        end
        if (load_out)
        begin
            out_row_reg <= pend_row_reg;
            out_start_reg <= pend_start_reg;
            out_end_reg <= pend_end_reg;
            out_color_reg <= pend_color_reg;
            out_last_reg <= out_last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign span_row = out_row_reg;
    assign span_start = out_start_reg;
    assign span_end = out_end_reg;
    assign span_color = out_color_reg;
    assign span_last = out_last_reg;

    `ASSERT_IMPLIES(a_push_not_flush, ctl.push, !ctl.flush, "push and flush together")
    `ASSERT_NEXT(a_push_moves_pend, ctl.push && sts.push_ready && pend_valid_reg, out_valid_reg && !out_last_reg, "pending span not moved on push")
    `ASSERT_NEXT(a_flush_empties, ctl.flush && sts.flush_done, !pend_valid_reg, "flush left a pending span")

endmodule

`default_nettype wire

FILE: rtl/triangle_span_rasterizer.sv
// Triangle span rasterizer top level: config registers, sequencer and edge walk.
//
// Input channel (in_valid/in_ready): one beat is a triangle, three signed
// vertices plus fill_color. in_ready is high only while the sequencer is idle.
// Output channel (out_valid/out_ready): one beat per visible span, top to
// bottom, span_last set on the final span of a triangle. A triangle with no
// visible span gives no beat.
// Work per triangle: setup (sort, checks, edge setups), then per row a row
// check and the Bresenham steps of the short edge and of the long edge (plus
// an aim at the middle vertex), then a close-out. The one edge unit does a
// single step per cycle; rows above the band are still walked.
// The last span sits in the output register while the next triangle is taken.
// When the receiver stalls, the walk halts at the next visible row until the
// pending span can move into the output register.
// Reset clears the sequencer and both output stages, and loads the mask
// registers with left 0, top 0, right 1023, bottom 63.
// APB registers at byte addresses 0x0, 0x4, 0x8, 0xC: mask_left, mask_top,
// mask_right, mask_bottom; write them only while idle.
`default_nettype none

`include "assert_macros.svh"

module triangle_span_rasterizer #(
    parameter int BAND_ROWS = 64,
    parameter int COORD_BITS = 16,
    parameter int COLOR_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tsr_pkg::ADDR_BITS-1:0]       paddr,
    input  logic [tsr_pkg::DATA_BITS-1:0]       pwdata,
    output logic [tsr_pkg::DATA_BITS-1:0]       prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [COORD_BITS-1:0]        vert_a_x,
    input  logic signed [COORD_BITS-1:0]        vert_a_y,
    input  logic signed [COORD_BITS-1:0]        vert_b_x,
    input  logic signed [COORD_BITS-1:0]        vert_b_y,
    input  logic signed [COORD_BITS-1:0]        vert_c_x,
    input  logic signed [COORD_BITS-1:0]        vert_c_y,
    input  logic [COLOR_BITS-1:0]               fill_color,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [COORD_BITS-1:0]        span_row,
    output logic signed [COORD_BITS-1:0]        span_start,
    output logic signed [COORD_BITS-1:0]        span_end,
    output logic [COLOR_BITS-1:0]               span_color,
    output logic                                span_last
);

    localparam int WIDE = COORD_BITS + 1;
    localparam int ERR_BITS = COORD_BITS + 3;
    localparam int COORD_MAX = (1 << (COORD_BITS - 1)) - 1;
    localparam int RIGHT_RST = (tsr_pkg::MASK_RIGHT_RESET > COORD_MAX) ?
                               COORD_MAX : tsr_pkg::MASK_RIGHT_RESET;
    localparam int BOTTOM_RST = (tsr_pkg::MASK_BOTTOM_RESET > COORD_MAX) ?
                                COORD_MAX : tsr_pkg::MASK_BOTTOM_RESET;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0]        dx;
        logic [COORD_BITS-1:0]        dy;
        logic                         sxn;
        logic                         syn;
        logic signed [ERR_BITS-1:0]   err;
    } edge_st_t;

    logic signed [COORD_BITS-1:0] mask_left_reg;
    logic signed [COORD_BITS-1:0] mask_top_reg;
    logic signed [COORD_BITS-1:0] mask_right_reg;
    logic signed [COORD_BITS-1:0] mask_bottom_reg;

    tsr_pkg::tsr_state_t          state_reg;
    tsr_pkg::tsr_state_t          state_next;
    logic signed [COORD_BITS-1:0] vx_reg [3];
    logic signed [COORD_BITS-1:0] vx_next [3];
    logic signed [COORD_BITS-1:0] vy_reg [3];
    logic signed [COORD_BITS-1:0] vy_next [3];
    logic [COLOR_BITS-1:0]        color_reg;
    logic [COLOR_BITS-1:0]        color_next;
    edge_st_t                     e1_reg;
    edge_st_t                     e1_next;
    edge_st_t                     e2_reg;
    edge_st_t                     e2_next;
    logic signed [COORD_BITS-1:0] row0_reg;
    logic signed [COORD_BITS-1:0] row0_next;
    logic signed [WIDE-1:0]       bottom_reg;
    logic signed [WIDE-1:0]       bottom_next;

    tsr_pkg::edge_op_t            eu_op;
    logic signed [COORD_BITS-1:0] eu_a_x;
    logic signed [COORD_BITS-1:0] eu_a_y;
    logic signed [COORD_BITS-1:0] eu_b_x;
    logic signed [COORD_BITS-1:0] eu_b_y;
    edge_st_t                     eu_in;
    edge_st_t                     eu_out;

    tsr_pkg::span_ctl_t           ctl;
    tsr_pkg::span_sts_t           sts;

    logic                         cfg_write;
    logic                         e1_at_v1;
    logic                         e1_at_v2;
    logic                         e2_at_v2;
    logic                         degenerate;
    logic signed [WIDE-1:0]       e1x_w;
    logic signed [WIDE-1:0]       e2x_w;
    logic signed [WIDE-1:0]       row_w;
    logic signed [WIDE-1:0]       left_w;
    logic signed [WIDE-1:0]       right_w;
    logic signed [WIDE-1:0]       top_w;
    logic signed [WIDE-1:0]       bot_w;
    logic signed [WIDE-1:0]       band_w;
    logic signed [WIDE-1:0]       lo_w;
    logic signed [WIDE-1:0]       hi_w;
    logic                         visible;

    // configuration port
    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_left_reg <= '0;
            mask_top_reg <= '0;
            mask_right_reg <= COORD_BITS'(RIGHT_RST);
            mask_bottom_reg <= COORD_BITS'(BOTTOM_RST);
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                tsr_pkg::REG_MASK_LEFT:   mask_left_reg <= pwdata[COORD_BITS-1:0];
                tsr_pkg::REG_MASK_TOP:    mask_top_reg <= pwdata[COORD_BITS-1:0];
                tsr_pkg::REG_MASK_RIGHT:  mask_right_reg <= pwdata[COORD_BITS-1:0];
                tsr_pkg::REG_MASK_BOTTOM: mask_bottom_reg <= pwdata[COORD_BITS-1:0];
                default:                  mask_left_reg <= mask_left_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            tsr_pkg::REG_MASK_LEFT:
                prdata = {{(tsr_pkg::DATA_BITS-COORD_BITS){mask_left_reg[COORD_BITS-1]}},
                          mask_left_reg};
            tsr_pkg::REG_MASK_TOP:
                prdata = {{(tsr_pkg::DATA_BITS-COORD_BITS){mask_top_reg[COORD_BITS-1]}},
                          mask_top_reg};
            tsr_pkg::REG_MASK_RIGHT:
                prdata = {{(tsr_pkg::DATA_BITS-COORD_BITS){mask_right_reg[COORD_BITS-1]}},
                          mask_right_reg};
            tsr_pkg::REG_MASK_BOTTOM:
                prdata = {{(tsr_pkg::DATA_BITS-COORD_BITS){mask_bottom_reg[COORD_BITS-1]}},
                          mask_bottom_reg};
            default:
                prdata = '0;
        endcase
    end

    // span arithmetic for the current row
    always_comb
    begin
        e1x_w = {e1_reg.x[COORD_BITS-1], e1_reg.x};
        e2x_w = {e2_reg.x[COORD_BITS-1], e2_reg.x};
        row_w = {e1_reg.y[COORD_BITS-1], e1_reg.y};
        left_w = {mask_left_reg[COORD_BITS-1], mask_left_reg};
        right_w = {mask_right_reg[COORD_BITS-1], mask_right_reg};
        top_w = {mask_top_reg[COORD_BITS-1], mask_top_reg};
        bot_w = {mask_bottom_reg[COORD_BITS-1], mask_bottom_reg};
        band_w = top_w + WIDE'(BAND_ROWS - 1);
        lo_w = (e1x_w < e2x_w) ? e1x_w : e2x_w;
        hi_w = ((e1x_w > e2x_w) ? e1x_w : e2x_w) - 1'b1;
        if (lo_w < left_w)
        begin
            lo_w = left_w;
        end
        if (hi_w > right_w)
        begin
            hi_w = right_w;
        end
        visible = (row_w >= top_w) && (lo_w <= hi_w);
    end

    assign e1_at_v1 = (e1_reg.x == vx_reg[1]) && (e1_reg.y == vy_reg[1]);
    assign e1_at_v2 = (e1_reg.x == vx_reg[2]) && (e1_reg.y == vy_reg[2]);
    assign e2_at_v2 = (e2_reg.x == vx_reg[2]) && (e2_reg.y == vy_reg[2]);
    assign degenerate = ((vx_reg[0] == vx_reg[1]) && (vy_reg[0] == vy_reg[1])) ||
                        ((vx_reg[1] == vx_reg[2]) && (vy_reg[1] == vy_reg[2])) ||
                        ((vx_reg[0] == vx_reg[2]) && (vy_reg[0] == vy_reg[2])) ||
                        ((vx_reg[0] == vx_reg[1]) && (vx_reg[1] == vx_reg[2])) ||
                        ((vy_reg[0] == vy_reg[1]) && (vy_reg[1] == vy_reg[2]));

    // edge unit operand select
    always_comb
    begin
        eu_op = tsr_pkg::OP_MOVE;
        eu_a_x = vx_reg[1];
        eu_a_y = vy_reg[1];
        eu_b_x = vx_reg[2];
        eu_b_y = vy_reg[2];
        eu_in = e1_reg;
        case (state_reg)
            tsr_pkg::ST_AIM1:
            begin
                eu_op = tsr_pkg::OP_AIM;
                eu_a_x = vx_reg[0];
                eu_a_y = vy_reg[0];
                eu_b_x = vx_reg[1];
                eu_b_y = vy_reg[1];
            end
            tsr_pkg::ST_AIM2:
            begin
                eu_op = tsr_pkg::OP_AIM;
                eu_a_x = vx_reg[0];
                eu_a_y = vy_reg[0];
            end
            tsr_pkg::ST_E1:
            begin
                eu_op = e1_at_v1 ? tsr_pkg::OP_AIM : tsr_pkg::OP_MOVE;
            end
            tsr_pkg::ST_E2:
            begin
                eu_in = e2_reg;
            end
            default:
            begin
                eu_op = tsr_pkg::OP_MOVE;
            end
        endcase
    end

    tsr_edge_unit #(
        .COORD_BITS (COORD_BITS),
        .ERR_BITS   (ERR_BITS)
    ) u_edge (
        .op      (eu_op),
        .a_x     (eu_a_x),
        .a_y     (eu_a_y),
        .b_x     (eu_b_x),
        .b_y     (eu_b_y),
        .in_x    (eu_in.x),
        .in_y    (eu_in.y),
        .in_dx   (eu_in.dx),
        .in_dy   (eu_in.dy),
        .in_sxn  (eu_in.sxn),
        .in_syn  (eu_in.syn),
        .in_err  (eu_in.err),
        .out_x   (eu_out.x),
        .out_y   (eu_out.y),
        .out_dx  (eu_out.dx),
        .out_dy  (eu_out.dy),
        .out_sxn (eu_out.sxn),
        .out_syn (eu_out.syn),
        .out_err (eu_out.err)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        vx_next = vx_reg;
        vy_next = vy_reg;
        color_next = color_reg;
        e1_next = e1_reg;
        e2_next = e2_reg;
        row0_next = row0_reg;
        bottom_next = bottom_reg;
        in_ready = 1'b0;
        ctl = '0;
        case (state_reg)
            tsr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    vx_next[0] = vert_a_x;
                    vy_next[0] = vert_a_y;
                    vx_next[1] = vert_b_x;
                    vy_next[1] = vert_b_y;
                    vx_next[2] = vert_c_x;
                    vy_next[2] = vert_c_y;
                    for (int i = 0; i < COLOR_BITS; i++)
                    begin
                        color_next[i] = (i < tsr_pkg::COLOR_KEEP_BITS) ? fill_color[i] : 1'b0;
                    end
                    state_next = tsr_pkg::ST_SORT0;
                end
            end
            tsr_pkg::ST_SORT0, tsr_pkg::ST_SORT2:
            begin
                if (vy_reg[1] < vy_reg[0])
                begin
                    vx_next[0] = vx_reg[1];
                    vy_next[0] = vy_reg[1];
                    vx_next[1] = vx_reg[0];
                    vy_next[1] = vy_reg[0];
                end
                state_next = (state_reg == tsr_pkg::ST_SORT0) ?
                             tsr_pkg::ST_SORT1 : tsr_pkg::ST_CHECK;
            end
            tsr_pkg::ST_SORT1:
            begin
                if (vy_reg[2] < vy_reg[1])
                begin
                    vx_next[1] = vx_reg[2];
                    vy_next[1] = vy_reg[2];
                    vx_next[2] = vx_reg[1];
                    vy_next[2] = vy_reg[1];
                end
                state_next = tsr_pkg::ST_SORT2;
            end
            tsr_pkg::ST_CHECK:
            begin
                bottom_next = (band_w < bot_w) ? band_w : bot_w;
                state_next = degenerate ? tsr_pkg::ST_IDLE : tsr_pkg::ST_AIM1;
            end
            tsr_pkg::ST_AIM1:
            begin
                e1_next = eu_out;
                state_next = tsr_pkg::ST_AIM2;
            end
            tsr_pkg::ST_AIM2:
            begin
                e2_next = eu_out;
                state_next = tsr_pkg::ST_ROW;
            end
            tsr_pkg::ST_ROW:
            begin
                if (row_w > bottom_reg)
                begin
                    state_next = tsr_pkg::ST_FLUSH;
                end
                else
                begin
                    ctl.push = visible;
                    if (!visible || sts.push_ready)
                    begin
                        row0_next = e1_reg.y;
                        state_next = tsr_pkg::ST_E1;
                    end
                end
            end
            tsr_pkg::ST_E1:
            begin
                if (e1_at_v1)
                begin
                    e1_next = eu_out;
                    state_next = tsr_pkg::ST_E1_MV;
                end
                else if (e1_at_v2)
                begin
                    state_next = tsr_pkg::ST_FLUSH;
                end
                else
                begin
                    e1_next = eu_out;
                    if (eu_out.y != row0_reg)
                    begin
                        state_next = tsr_pkg::ST_E2;
                    end
                end
            end
            tsr_pkg::ST_E1_MV:
            begin
                e1_next = eu_out;
                state_next = (eu_out.y != row0_reg) ? tsr_pkg::ST_E2 : tsr_pkg::ST_E1;
            end
            tsr_pkg::ST_E2:
            begin
                if (e2_at_v2)
                begin
                    state_next = tsr_pkg::ST_FLUSH;
                end
                else
                begin
                    e2_next = eu_out;
                    if (eu_out.y != row0_reg)
                    begin
                        state_next = tsr_pkg::ST_ROW;
                    end
                end
            end
            tsr_pkg::ST_FLUSH:
            begin
                ctl.flush = 1'b1;
                if (sts.flush_done)
                begin
                    state_next = tsr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tsr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tsr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vx_reg <= vx_next;
        vy_reg <= vy_next;
        color_reg <= color_next;
        e1_reg <= e1_next;
        e2_reg <= e2_next;
        row0_reg <= row0_next;
        bottom_reg <= bottom_next;
    end

    tsr_span_out #(
        .COORD_BITS (COORD_BITS),
        .COLOR_BITS (COLOR_BITS)
    ) u_span_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sts        (sts),
        .push_row   (e1_reg.y),
        .push_start (lo_w[COORD_BITS-1:0]),
        .push_end   (hi_w[COORD_BITS-1:0]),
        .push_color (color_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .span_row   (span_row),
        .span_start (span_start),
        .span_end   (span_end),
        .span_color (span_color),
        .span_last  (span_last)
    );

    `ASSERT_IMPLIES(a_sorted, state_reg == tsr_pkg::ST_CHECK, (vy_reg[0] <= vy_reg[1]) && (vy_reg[1] <= vy_reg[2]), "vertices not sorted by y")
    `ASSERT_IMPLIES(a_rows_in_step, state_reg == tsr_pkg::ST_ROW, e1_reg.y == e2_reg.y, "edges not on the same row")
    `ASSERT_IMPLIES(a_span_in_band, ctl.push, (row_w >= top_w) && (row_w <= bottom_reg) && (lo_w <= hi_w), "span outside band")

endmodule

`default_nettype wire
